/* rtl/tlru_pkg.sv */
// ----------------------------------------------------------------------------
// tlru_pkg
// shared types and codes for the two-list lru page replacement core
// ----------------------------------------------------------------------------
package tlru_pkg;

  localparam int unsigned FIELD_PAGE_W = 20;
  localparam int unsigned CFG_IDX_W    = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SIZE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SIZE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WS_MAX_SIZE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_FIRST   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_END     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STACK_FIRST  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STACK_END    = 3'd6;

  typedef enum logic [2:0] {
    OUT_PLACED   = 3'd0,
    OUT_PROMOTED = 3'd1,
    OUT_DEMOTED  = 3'd2,
    OUT_EVICTED  = 3'd3,
    OUT_NONE     = 3'd4
  } outcome_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRD,
    ST_SCMP,
    ST_SHRD,
    ST_SHWR,
    ST_EVRD,
    ST_EVWB,
    ST_DMRD,
    ST_DMWB,
    ST_PUSH,
    ST_DONE
  } state_e;

endpackage

/* rtl/two_list_lru_page_replacement_core.sv */
// sequence: a killed placement or no action goes straight to the output register; a
// placement pushes the page first; a promotion reads and compares second-list entries,
// shifts the entries ahead of the hit (read, write), demotes (read, write back), pushes
// and registers the result; one request at a time, taken only while the sequencer idles
// the next request is taken while a finished result still waits at the output
// reset: counts and ring heads clear at once, list memories need no clearing pass
// ----------------------------------------------------------------------------
// two_list_lru_page_replacement_core
// active and second-chance page lists held as ring buffers in synchronous memories
// ----------------------------------------------------------------------------
module two_list_lru_page_replacement_core
  import tlru_pkg::*;
#(
  parameter int unsigned ACTIVE_DEPTH = 16,
  parameter int unsigned SECOND_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // fault requests
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,   // [19:0] fault_page, rest zero
  input  logic                 s_axis_tuser,   // [0] in_page_file
  // results
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [47:0]          m_axis_tdata,   // [0] demoted_valid, [20:1] demoted_page,
                                               // [21] evicted_valid, [41:22] evicted_page
  output logic [3:0]           m_axis_tuser,   // [2:0] outcome, [3] killed
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [19:0]          cfg_data_i
);

  // page number width follows the fixed field width of the stream ports
  localparam int unsigned PAGE_BITS = FIELD_PAGE_W;

  // pointer and count widths for each ring
  localparam int unsigned AAW  = (ACTIVE_DEPTH > 1) ? $clog2(ACTIVE_DEPTH) : 1;
  localparam int unsigned SAW  = (SECOND_DEPTH > 1) ? $clog2(SECOND_DEPTH) : 1;
  localparam int unsigned ACW  = $clog2(ACTIVE_DEPTH + 1);
  localparam int unsigned SCW  = $clog2(SECOND_DEPTH + 1);
  localparam int unsigned CMPW = 10;   // holds the sum of both counts and every limit

  // ring address helpers: base plus logical offset, wrapped once
  function automatic logic [AAW-1:0] a_pos(input logic [AAW-1:0] b, input logic [ACW-1:0] k);
    logic [ACW:0] s;
    s = (ACW+1)'(b) + (ACW+1)'(k);
    if (s >= (ACW+1)'(ACTIVE_DEPTH)) s = s - (ACW+1)'(ACTIVE_DEPTH);
    return AAW'(s);
  endfunction

  function automatic logic [SAW-1:0] s_pos(input logic [SAW-1:0] b, input logic [SCW-1:0] k);
    logic [SCW:0] s;
    s = (SCW+1)'(b) + (SCW+1)'(k);
    if (s >= (SCW+1)'(SECOND_DEPTH)) s = s - (SCW+1)'(SECOND_DEPTH);
    return SAW'(s);
  endfunction

  function automatic logic [AAW-1:0] a_dec(input logic [AAW-1:0] b);
    return (b == '0) ? AAW'(ACTIVE_DEPTH - 1) : AAW'(b - 1'b1);
  endfunction

  function automatic logic [SAW-1:0] s_dec(input logic [SAW-1:0] b);
    return (b == '0) ? SAW'(SECOND_DEPTH - 1) : SAW'(b - 1'b1);
  endfunction

  // configuration registers
  logic [4:0]  active_size_q, second_size_q;
  logic [5:0]  ws_max_q;
  logic [19:0] heap_first_q, heap_end_q, stack_first_q, stack_end_q;

  // list state
  logic [ACW-1:0] ac_q, ac_d;
  logic [SCW-1:0] sc_q, sc_d;
  logic [AAW-1:0] ahead_q, ahead_d;
  logic [SAW-1:0] shead_q, shead_d;

  // per-request working registers
  state_e         state_q, state_d;
  logic [PAGE_BITS-1:0] p_q, p_d;
  logic           kill_q, kill_d;
  logic           full_q, full_d;     // working set at its limit
  logic           promo_q, promo_d;
  logic           push_q, push_d;
  logic [SCW-1:0] i_q, i_d;           // search index, then shift index
  outcome_e       outc_q, outc_d;
  logic           killed_q, killed_d;
  logic           dv_q, dv_d, ev_q, ev_d;
  logic [PAGE_BITS-1:0] dp_q, dp_d, ep_q, ep_d;

  // output register
  logic           out_valid_q, out_valid_d;
  logic [47:0]    out_data_q, out_data_d;
  logic [3:0]     out_user_q, out_user_d;

  // memories
  logic [PAGE_BITS-1:0] amem [ACTIVE_DEPTH];
  logic [PAGE_BITS-1:0] smem [SECOND_DEPTH];
  logic [PAGE_BITS-1:0] ard_q, srd_q;
  logic [AAW-1:0]       a_raddr, a_waddr;
  logic [SAW-1:0]       s_raddr, s_waddr;
  logic                 a_we, s_we;
  logic [PAGE_BITS-1:0] a_wdata, s_wdata;

  // request decode
  logic [PAGE_BITS-1:0] in_page;
  logic [19:0]          cmp_page;
  logic                 in_kill;
  logic [CMPW-1:0]      alim, slim, sum_cnt;
  logic                 ws_room, act_room, try_second;
  logic                 in_acc;

  assign in_page  = PAGE_BITS'(s_axis_tdata[19:0]);
  assign cmp_page = 20'(in_page);
  assign in_kill  = !s_axis_tuser
                    && !(cmp_page >= heap_first_q && cmp_page < heap_end_q)
                    && !(cmp_page >= stack_first_q && cmp_page < stack_end_q);

  // limits above the memory depth behave as the depth
  assign alim = (CMPW'(active_size_q) < CMPW'(ACTIVE_DEPTH)) ? CMPW'(active_size_q)
                                                              : CMPW'(ACTIVE_DEPTH);
  assign slim = (CMPW'(second_size_q) < CMPW'(SECOND_DEPTH)) ? CMPW'(second_size_q)
                                                              : CMPW'(SECOND_DEPTH);
  assign sum_cnt    = CMPW'(ac_q) + CMPW'(sc_q);
  assign ws_room    = sum_cnt < CMPW'(ws_max_q);
  assign act_room   = CMPW'(ac_q) < alim;
  assign try_second = !ws_room || (CMPW'(ac_q) == alim && CMPW'(sc_q) < slim);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // sequencer: next state, list updates and memory accesses
  always_comb begin
    logic go_dem;
    logic no_hit;
    go_dem      = 1'b0;
    no_hit      = 1'b0;
    state_d     = state_q;
    ac_d        = ac_q;
    sc_d        = sc_q;
    ahead_d     = ahead_q;
    shead_d     = shead_q;
    p_d         = p_q;
    kill_d      = kill_q;
    full_d      = full_q;
    promo_d     = promo_q;
    push_d      = push_q;
    i_d         = i_q;
    outc_d      = outc_q;
    killed_d    = killed_q;
    dv_d        = dv_q;
    ev_d        = ev_q;
    dp_d        = dp_q;
    ep_d        = ep_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    a_raddr     = a_pos(ahead_q, ACW'(ac_q - 1'b1));
    s_raddr     = s_pos(shead_q, i_q);
    a_we        = 1'b0;
    s_we        = 1'b0;
    a_waddr     = a_dec(ahead_q);
    s_waddr     = s_dec(shead_q);
    a_wdata     = p_q;
    s_wdata     = ard_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          p_d      = in_page;
          kill_d   = in_kill;
          full_d   = !ws_room;
          promo_d  = 1'b0;
          push_d   = 1'b0;
          i_d      = '0;
          dv_d     = 1'b0;
          ev_d     = 1'b0;
          dp_d     = '0;
          ep_d     = '0;
          killed_d = 1'b0;
          outc_d   = OUT_NONE;
          if (ws_room && act_room) begin
            outc_d   = OUT_PLACED;
            killed_d = in_kill;
            push_d   = !in_kill;
            state_d  = in_kill ? ST_DONE : ST_PUSH;
          end else if (try_second) begin
            if (sc_q == '0) begin
              // nothing to search: straight to the miss path
              if (!ws_room) outc_d = OUT_EVICTED;
              else          outc_d = OUT_DEMOTED;
              killed_d = in_kill;
              push_d   = !in_kill;
              go_dem   = 1'b1;
            end else begin
              state_d = ST_SRD;
            end
          end else begin
            state_d = ST_DONE;
          end
        end
      end

      ST_SRD: begin
        state_d = ST_SCMP;
      end

      ST_SCMP: begin
        if (srd_q == p_q) begin
          outc_d  = OUT_PROMOTED;
          promo_d = 1'b1;
          push_d  = 1'b1;
          if (i_q == '0) go_dem = 1'b1;
          else           state_d = ST_SHRD;
        end else if (SCW'(i_q + 1'b1) < sc_q) begin
          i_d     = SCW'(i_q + 1'b1);
          state_d = ST_SRD;
        end else begin
          no_hit = 1'b1;
        end
      end

      // close the gap: entries ahead of the hit move one place towards the tail
      ST_SHRD: begin
        s_raddr = s_pos(shead_q, SCW'(i_q - 1'b1));
        state_d = ST_SHWR;
      end

      ST_SHWR: begin
        s_we    = 1'b1;
        s_waddr = s_pos(shead_q, i_q);
        s_wdata = srd_q;
        i_d     = SCW'(i_q - 1'b1);
        if (SCW'(i_q - 1'b1) == '0) go_dem = 1'b1;
        else                        state_d = ST_SHRD;
      end

      ST_EVRD: begin
        s_raddr = s_pos(shead_q, SCW'(sc_q - 1'b1));
        state_d = ST_EVWB;
      end

      ST_EVWB: begin
        ev_d   = 1'b1;
        ep_d   = srd_q;
        sc_d   = SCW'(sc_q - 1'b1);
        go_dem = 1'b1;
      end

      ST_DMRD: begin
        state_d = ST_DMWB;
      end

      ST_DMWB: begin
        dv_d = 1'b1;
        dp_d = ard_q;
        ac_d = ACW'(ac_q - 1'b1);
        s_we = 1'b1;
        if (promo_q) begin
          // the freed head slot takes the demoted page
          s_waddr = shead_q;
        end else begin
          shead_d = s_dec(shead_q);
          sc_d    = SCW'(sc_q + 1'b1);
        end
        state_d = push_q ? ST_PUSH : ST_DONE;
      end

      ST_PUSH: begin
        a_we    = 1'b1;
        ahead_d = a_dec(ahead_q);
        ac_d    = ACW'(ac_d + 1'b1);
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {6'b0, 20'(ep_q), ev_q, 20'(dp_q), dv_q};
          out_user_d  = {killed_q, outc_q};
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // search missed: evict when the working set is full, then demote
    if (no_hit) begin
      outc_d   = full_q ? OUT_EVICTED : OUT_DEMOTED;
      killed_d = kill_q;
      push_d   = !kill_q;
      if (full_q) state_d = ST_EVRD;
      else        go_dem  = 1'b1;
    end

    // demotion step, or skip it when the active list is empty
    if (go_dem) begin
      if (ac_d != '0) begin
        state_d = ST_DMRD;
      end else begin
        if (promo_d) begin
          shead_d = s_pos(shead_q, SCW'(1));
          sc_d    = SCW'(sc_d - 1'b1);
        end
        state_d = push_d ? ST_PUSH : ST_DONE;
      end
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (a_we) amem[a_waddr] <= a_wdata;
    ard_q <= amem[a_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (s_we) smem[s_waddr] <= s_wdata;
    srd_q <= smem[s_raddr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      ac_q          <= '0;
      sc_q          <= '0;
      ahead_q       <= '0;
      shead_q       <= '0;
      out_valid_q   <= 1'b0;
      active_size_q <= 5'd16;
      second_size_q <= 5'd16;
      ws_max_q      <= 6'd32;
      heap_first_q  <= '0;
      heap_end_q    <= '0;
      stack_first_q <= '0;
      stack_end_q   <= '0;
    end else begin
      state_q     <= state_d;
      ac_q        <= ac_d;
      sc_q        <= sc_d;
      ahead_q     <= ahead_d;
      shead_q     <= shead_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_ACTIVE_SIZE: active_size_q <= cfg_data_i[4:0];
          CFG_SECOND_SIZE: second_size_q <= cfg_data_i[4:0];
          CFG_WS_MAX_SIZE: ws_max_q      <= cfg_data_i[5:0];
          CFG_HEAP_FIRST:  heap_first_q  <= cfg_data_i;
          CFG_HEAP_END:    heap_end_q    <= cfg_data_i;
          CFG_STACK_FIRST: stack_first_q <= cfg_data_i;
          CFG_STACK_END:   stack_end_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    p_q        <= p_d;
    kill_q     <= kill_d;
    full_q     <= full_d;
    promo_q    <= promo_d;
    push_q     <= push_d;
    i_q        <= i_d;
    outc_q     <= outc_d;
    killed_q   <= killed_d;
    dv_q       <= dv_d;
    ev_q       <= ev_d;
    dp_q       <= dp_d;
    ep_q       <= ep_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

endmodule
